FILE: rtl/integer_to_ascii_radix_assert.svh
// ---------------------------------------------------------------------------
// integer_to_ascii_radix assertion macros
// Shared property forms for the checker; clk and arst_n come from the scope.
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_RADIX_ASSERT_SVH
`define INTEGER_TO_ASCII_RADIX_ASSERT_SVH

// same-cycle implication
`define ITOA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ITOA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/itoa_pkg.sv
// ---------------------------------------------------------------------------
// itoa_pkg
// Widths, character codes and helpers for the integer-to-text converter.
// ---------------------------------------------------------------------------
package itoa_pkg;

	localparam int VALUE_BITS = 16;
	localparam int RADIX_W    = 6;
	localparam int CHAR_W     = 7;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	// worst case is radix 2: one character per value bit
	localparam int MAX_CHARS  = VALUE_BITS;
	localparam int IDX_W      = $clog2(MAX_CHARS);
	localparam int CNT_W      = $clog2(MAX_CHARS + 1);
	localparam int BIT_CNT_W  = $clog2(VALUE_BITS);

	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
	localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
	localparam logic [RADIX_W-1:0] RADIX_DEC   = RADIX_W'(10);
	localparam logic [RADIX_W-1:0] DIGIT_TEN   = RADIX_W'(10);

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
	localparam logic [CHAR_W-1:0] CHAR_NINE  = CHAR_W'(57);
	localparam logic [CHAR_W-1:0] CHAR_A     = CHAR_W'(97);
	localparam logic [CHAR_W-1:0] CHAR_Z     = CHAR_W'(122);
	localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);

	// register index, taken from paddr[2]
	localparam logic REG_RADIX = 1'b0;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DIGIT_TEN) begin
			c = CHAR_ZERO + CHAR_W'(d);
		end else begin
			c = CHAR_A + CHAR_W'(d) - CHAR_W'(DIGIT_TEN);
		end
		return c;
	endfunction

endpackage

FILE: rtl/integer_to_ascii_radix.sv
// ---------------------------------------------------------------------------
// integer_to_ascii_radix
// Converts a signed integer to ASCII text in a programmable radix.
// ---------------------------------------------------------------------------
// One value beat gives its text as one character beat per digit or sign, most
// significant first, last_char set on the final one. Radix register at byte
// address 0 (reset 10; 0..1 act as 2, 37..63 act as 36). Radix 10 prints a
// leading '-' for negatives; other radices print the raw 16-bit pattern.
// Digits come from one shared restoring compare-subtract unit that yields a
// quotient bit per cycle; each digit runs ST_DIV over all value bits, then
// ST_PUSH stores it on the character stack. Once the digits (and a sign)
// are stacked, characters load one per cycle unless the output stalls;
// in_stall stays high from accept until the last character is loaded into
// the output register.
// ---------------------------------------------------------------------------
module integer_to_ascii_radix (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [itoa_pkg::VALUE_BITS-1:0] value,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic        [itoa_pkg::CHAR_W-1:0]     char_code,
	output logic                                   last_char,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic        [itoa_pkg::PADDR_W-1:0]    paddr,
	input  logic        [itoa_pkg::PDATA_W-1:0]    pwdata,
	output logic        [itoa_pkg::PDATA_W-1:0]    prdata,
	output logic                                   pready
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_PUSH,
		ST_SIGN,
		ST_EMIT
	} state_t;

	state_t                              state_q;
	logic [itoa_pkg::RADIX_W-1:0]        radix_q;
	logic [itoa_pkg::RADIX_W-1:0]        radix_eff_q;
	logic [itoa_pkg::VALUE_BITS-1:0]     mag_q;
	logic [itoa_pkg::RADIX_W-1:0]        rem_q;
	logic [itoa_pkg::BIT_CNT_W-1:0]      bit_cnt_q;
	logic [itoa_pkg::CNT_W-1:0]          cnt_q;
	logic                                neg_q;
	logic                                out_valid_q;
	logic [itoa_pkg::CHAR_W-1:0]         char_q;
	logic                                last_q;
	logic [itoa_pkg::CHAR_W-1:0]         buf_q [itoa_pkg::MAX_CHARS];

	logic                                cfg_wr;
	logic                                in_accept;
	logic                                out_take;
	logic                                load_out;
	logic [itoa_pkg::RADIX_W-1:0]        radix_eff;
	logic [itoa_pkg::VALUE_BITS-1:0]     value_u;
	logic                                neg_w;
	logic [itoa_pkg::VALUE_BITS-1:0]     mag_init;
	logic [itoa_pkg::RADIX_W:0]          trial;
	logic [itoa_pkg::RADIX_W:0]          diff;
	logic                                q_bit;
	logic [itoa_pkg::IDX_W-1:0]          wr_idx;
	logic [itoa_pkg::IDX_W-1:0]          rd_idx;

	// APB
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == itoa_pkg::REG_RADIX);
	assign prdata = (paddr[2] == itoa_pkg::REG_RADIX)
		? {{(itoa_pkg::PDATA_W - itoa_pkg::RADIX_W){1'b0}}, radix_q}
		: '0;

	always_comb begin
		if (radix_q < itoa_pkg::RADIX_MIN) begin
			radix_eff = itoa_pkg::RADIX_MIN;
		end else if (radix_q > itoa_pkg::RADIX_MAX) begin
			radix_eff = itoa_pkg::RADIX_MAX;
		end else begin
			radix_eff = radix_q;
		end
	end

	assign value_u  = $unsigned(value);
	assign neg_w    = (radix_eff == itoa_pkg::RADIX_DEC) && value_u[itoa_pkg::VALUE_BITS-1];
	assign mag_init = neg_w ? (~value_u + 1'b1) : value_u;

	// shared divider step: shift in next dividend bit, subtract radix if it fits
	assign trial = {rem_q, mag_q[itoa_pkg::VALUE_BITS-1]};
	assign diff  = trial - {1'b0, radix_eff_q};
	assign q_bit = (trial >= {1'b0, radix_eff_q});

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;
	assign load_out  = (state_q == ST_EMIT) && (!out_valid_q || out_take);

	assign wr_idx = cnt_q[itoa_pkg::IDX_W-1:0];
	assign rd_idx = cnt_q[itoa_pkg::IDX_W-1:0] - 1'b1;

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last_char = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			radix_q     <= itoa_pkg::RADIX_RESET;
			bit_cnt_q   <= '0;
			cnt_q       <= '0;
			neg_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				radix_q <= pwdata[itoa_pkg::RADIX_W-1:0];
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q   <= ST_DIV;
						bit_cnt_q <= '0;
						cnt_q     <= '0;
						neg_q     <= neg_w;
					end
				end
				ST_DIV: begin
					bit_cnt_q <= bit_cnt_q + 1'b1;
					if (bit_cnt_q == itoa_pkg::BIT_CNT_W'(itoa_pkg::VALUE_BITS - 1)) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					cnt_q <= cnt_q + 1'b1;
					if (mag_q != '0) begin
						state_q   <= ST_DIV;
						bit_cnt_q <= '0;
					end else if (neg_q) begin
						state_q <= ST_SIGN;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_SIGN: begin
					cnt_q   <= cnt_q + 1'b1;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (load_out) begin
						cnt_q <= cnt_q - 1'b1;
						if (cnt_q == itoa_pkg::CNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath and character stack
	always_ff @(posedge clk) begin
		if (in_accept) begin
			mag_q       <= mag_init;
			rem_q       <= '0;
			radix_eff_q <= radix_eff;
		end
		if (state_q == ST_DIV) begin
			mag_q <= {mag_q[itoa_pkg::VALUE_BITS-2:0], q_bit};
			rem_q <= q_bit ? diff[itoa_pkg::RADIX_W-1:0] : trial[itoa_pkg::RADIX_W-1:0];
		end
		if (state_q == ST_PUSH) begin
			buf_q[wr_idx] <= itoa_pkg::digit_char(rem_q);
			rem_q         <= '0;
		end
		if (state_q == ST_SIGN) begin
			buf_q[wr_idx] <= itoa_pkg::CHAR_MINUS;
		end
		if (load_out) begin
			char_q <= buf_q[rd_idx];
			last_q <= (cnt_q == itoa_pkg::CNT_W'(1));
		end
	end

endmodule

FILE: rtl/itoa_checker.sv
// ---------------------------------------------------------------------------
// itoa_checker
// Port-level checks for integer_to_ascii_radix, bound into that module.
// ---------------------------------------------------------------------------
`include "integer_to_ascii_radix_assert.svh"

module itoa_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [itoa_pkg::CHAR_W-1:0]       char_code,
	input logic                              last_char
);

	logic in_take;
	logic out_wait;
	logic char_ok;

	assign in_take  = in_valid && !in_stall;
	assign out_wait = out_valid && out_stall;
	assign char_ok  = (char_code == itoa_pkg::CHAR_MINUS)
		|| ((char_code >= itoa_pkg::CHAR_ZERO) && (char_code <= itoa_pkg::CHAR_NINE))
		|| ((char_code >= itoa_pkg::CHAR_A) && (char_code <= itoa_pkg::CHAR_Z));

	`ITOA_ASSERT_NXT(a_valid_hold, out_wait, out_valid, "stalled output beat dropped")

	`ITOA_ASSERT_NXT(a_data_hold, out_wait, $stable({char_code, last_char}), "stalled beat changed")

	// converter is busy right after taking a value
	`ITOA_ASSERT_NXT(a_busy_after_accept, in_take, in_stall, "input not stalled after accept")

	`ITOA_ASSERT_NOW(a_char_legal, out_valid, char_ok, "illegal character code")

endmodule

bind integer_to_ascii_radix itoa_checker u_itoa_checker (.*);

FILE: tb/sv/itoa_text_checker.sv
// ----------------------------------------------------------------------------
// itoa_text_checker
// Watches the value and character channels and the radix register writes,
// predicts the text of every accepted value and compares each character beat.
// ----------------------------------------------------------------------------
module itoa_text_checker
	import itoa_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [VALUE_BITS-1:0]        value,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [CHAR_W-1:0]            char_code,
	input  logic                         last_char,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic                         pready,
	input  logic [PADDR_W-1:0]           paddr,
	input  logic [PDATA_W-1:0]           pwdata,
	output int                           mismatches,
	output int                           chars_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} text_char_t;

	text_char_t         expected_text[$];
	logic [RADIX_W-1:0] radix_copy = RADIX_RESET;
	int                 mismatch_count = 0;
	int                 owed = 0;

	assign mismatches = mismatch_count;
	assign chars_owed = owed;

	task automatic note_mismatch(input string what, input int want, input int got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
		end
	endtask

	// queue the characters of one value, most significant first
	function automatic void spell_value(input logic [VALUE_BITS-1:0] pattern,
			input logic [RADIX_W-1:0] setting);
		logic [RADIX_W-1:0]    base;
		logic [VALUE_BITS-1:0] mag;
		logic [RADIX_W-1:0]    digit;
		logic                  negative;
		logic [CHAR_W-1:0]     reversed[$];
		text_char_t            entry;
		base = (setting < RADIX_MIN) ? RADIX_MIN : ((setting > RADIX_MAX) ? RADIX_MAX : setting);
		negative = (base == RADIX_DEC) && pattern[VALUE_BITS-1];
		mag = negative ? -pattern : pattern;
		// zero still yields one digit
		do begin
			digit = RADIX_W'(mag % VALUE_BITS'(base));
			if (digit < DIGIT_TEN) begin
				reversed.push_back(CHAR_ZERO + CHAR_W'(digit));
			end else begin
				reversed.push_back(CHAR_A + CHAR_W'(digit - DIGIT_TEN));
			end
			mag = mag / VALUE_BITS'(base);
		end while (mag != 0);
		if (negative) begin
			reversed.push_back(CHAR_MINUS);
		end
		for (int i = reversed.size() - 1; i >= 0; i--) begin
			entry.code = reversed[i];
			entry.last = (i == 0);
			expected_text.push_back(entry);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		text_char_t want;
		if (!arst_n) begin
			radix_copy <= RADIX_RESET;
			expected_text.delete();
			owed <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == REG_RADIX) begin
				radix_copy <= pwdata[RADIX_W-1:0];
			end
			if (out_valid && !out_stall) begin
				if (expected_text.size() == 0) begin
					note_mismatch("char beat with nothing owed", 0, char_code);
				end else begin
					want = expected_text.pop_front();
					if (char_code !== want.code) begin
						note_mismatch("char_code", want.code, char_code);
					end
					if (last_char !== want.last) begin
						note_mismatch("last_char", want.last, last_char);
					end
				end
			end
			// the user writes only while idle (DUT does not enforce it); old radix in force
			if (in_valid && !in_stall) begin
				spell_value(value, radix_copy);
			end
			owed <= expected_text.size();
		end
	end

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives values and radix settings into integer_to_ascii_radix with random
// idling on both channels; the checker predicts and compares the text.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import itoa_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 320;
	localparam int PHASE_ITEMS   = 26;
	localparam int PHASES        = 12;
	localparam logic [PADDR_W-1:0] RADIX_ADDR = PADDR_W'({REG_RADIX, 2'b00});

	localparam logic [VALUE_BITS-1:0] DEC_CASES [10] = '{
		16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001,
		16'd9, 16'd10, 16'hFFFB, 16'h5555, 16'hAAAA
	};
	localparam logic [VALUE_BITS-1:0] WIDE_CASES [4] = '{
		16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF
	};
	localparam logic [VALUE_BITS-1:0] B36_CASES [4] = '{
		16'd35, 16'd36, 16'hFFFF, 16'h7FFF
	};
	localparam logic [RADIX_W-1:0] PHASE_RADIX [PHASES] = '{
		6'd2, 6'd36, 6'd0, 6'd1, 6'd37, 6'd63, 6'd16, 6'd8, 6'd3, 6'd7, 6'd20, 6'd10
	};
	localparam int IDLE_PCT [4] = '{0, 5, 20, 40};

	logic                         clk;
	logic                         arst_n    = 1'b0;
	logic                         in_valid  = 1'b0;
	logic                         in_stall;
	logic signed [VALUE_BITS-1:0] value     = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [CHAR_W-1:0]            char_code;
	logic                         last_char;
	logic                         psel      = 1'b0;
	logic                         penable   = 1'b0;
	logic                         pwrite    = 1'b0;
	logic [PADDR_W-1:0]           paddr     = '0;
	logic [PDATA_W-1:0]           pwdata    = '0;
	logic [PDATA_W-1:0]           prdata;
	logic                         pready;

	int mismatches;
	int chars_owed;
	int gap_pct   = 0;
	int stall_pct = 0;
	int stall_run = 0;

	integer_to_ascii_radix i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.char_code (char_code),
		.last_char (last_char),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	itoa_text_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.char_code  (char_code),
		.last_char  (last_char),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.mismatches (mismatches),
		.chars_owed (chars_owed)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("testbench: errors");
		$finish;
	end

	// receiver stalls come in bursts of random length
	always @(posedge clk) begin
		if (stall_run != 0) begin
			out_stall <= 1'b1;
			stall_run <= stall_run - 1;
		end else if (stall_pct != 0 && $urandom_range(99, 0) < stall_pct) begin
			out_stall <= 1'b1;
			stall_run <= $urandom_range(18, 0);
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send_value(input logic [VALUE_BITS-1:0] v);
		if (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(19, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		do @(posedge clk); while (in_stall);
	endtask

	// drop valid and hold off until every owed character beat has gone out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (chars_owed != 0) @(posedge clk);
	endtask

	task automatic write_radix(input logic [RADIX_W-1:0] r);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= RADIX_ADDR;
		// upper data bits are junk the register must ignore
		pwdata  <= ($urandom() & ~PDATA_W'(6'h3F)) | PDATA_W'(r);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	function automatic logic [VALUE_BITS-1:0] pick_value();
		logic [VALUE_BITS-1:0] v;
		case ($urandom_range(4, 0))
			0, 1: begin
				v = VALUE_BITS'($urandom());
			end
			2: begin
				v = VALUE_BITS'($urandom()) >> $urandom_range(15, 1);
				if ($urandom_range(1, 0) == 1) v = -v;
			end
			3: begin
				v = VALUE_BITS'($urandom_range(40, 0));
				if ($urandom_range(1, 0) == 1) v = -v;
			end
			default: begin
				case ($urandom_range(3, 0))
					0: v = 16'h8000;
					1: v = 16'h7FFF;
					2: v = 16'hFFFF;
					default: v = 16'h0000;
				endcase
			end
		endcase
		return v;
	endfunction

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: default radix first, then both ends of the radix range
		gap_pct   = 20;
		stall_pct = 20;
		foreach (DEC_CASES[i]) send_value(DEC_CASES[i]);
		drain();
		write_radix(RADIX_MIN);
		foreach (WIDE_CASES[i]) send_value(WIDE_CASES[i]);
		drain();
		write_radix(RADIX_MAX);
		foreach (B36_CASES[i]) send_value(B36_CASES[i]);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			if (p == PHASES - 1) begin
				gap_pct   = 0;
				stall_pct = 0;
			end else begin
				gap_pct   = IDLE_PCT[$urandom_range(3, 0)];
				stall_pct = IDLE_PCT[$urandom_range(3, 0)];
			end
			write_radix(PHASE_RADIX[p]);
			repeat (PHASE_ITEMS) send_value(pick_value());
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && chars_owed == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/itoa_pkg.sv
rtl/integer_to_ascii_radix.sv
rtl/itoa_checker.sv
tb/sv/itoa_text_checker.sv
tb/sv/testbench.sv
